// ===== design/permutation_table_engine_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Permutation table engine assertion macros
// Shared property wrappers, clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_TABLE_ENGINE_UNIT_DEFINES_SVH
`define PERMUTATION_TABLE_ENGINE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTE_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTE_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/pte_pkg.sv =====
// ----------------------------------------------------------------------------
// Permutation table engine package
// Widths, command codes and sequencer states shared by the engine files.
// ----------------------------------------------------------------------------
package pte_pkg;

	localparam int MAX_LETTERS = 32;
	localparam int MAX_RESULTS = 16;
	localparam int LETTER_W    = $clog2(MAX_LETTERS);
	localparam int SIZE_W      = 6;
	localparam int CMD_W       = 3;
	localparam int IN_W        = 8;
	localparam int MODCNT_W    = $clog2(IN_W);
	localparam int PAIRCNT_W   = $clog2(MAX_RESULTS + 1);

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(26);

	localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SWAP   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RD_FWD = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RD_INV = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TEST   = 3'd4;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MOD,
		ST_LD_WR,
		ST_SW_P1,
		ST_SW_P2,
		ST_SW_R1,
		ST_SW_V1,
		ST_SW_R2,
		ST_SW_V2,
		ST_SW_W2,
		ST_SW_W3,
		ST_SW_W4,
		ST_RD_A,
		ST_RD_E,
		ST_T1_RD,
		ST_T1_CK,
		ST_T2_RD,
		ST_T2_CK,
		ST_T2_END
	} state_t;

endpackage

// ===== design/pte_ifs.sv =====
// ----------------------------------------------------------------------------
// Permutation table engine channels
// Valid/ready channels for configuration, command words and result words.
// ----------------------------------------------------------------------------
interface pte_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [pte_pkg::SIZE_W-1:0]    size_in_use;

	modport source (output valid, output size_in_use, input ready);
	modport sink   (input valid, input size_in_use, output ready);
endinterface

interface pte_item_if;
	logic                          valid;
	logic                          ready;
	logic [pte_pkg::CMD_W-1:0]     cmd;
	logic [pte_pkg::IN_W-1:0]      index_a;
	logic [pte_pkg::IN_W-1:0]      index_b;
	logic [pte_pkg::IN_W-1:0]      entry_value;

	modport source (output valid, output cmd, output index_a, output index_b,
		output entry_value, input ready);
	modport sink   (input valid, input cmd, input index_a, input index_b,
		input entry_value, output ready);
endinterface

interface pte_result_if;
	logic                          valid;
	logic                          ready;
	logic [pte_pkg::LETTER_W-1:0]  read_value;
	logic [pte_pkg::LETTER_W-1:0]  pair_first;
	logic [pte_pkg::LETTER_W-1:0]  pair_second;
	logic                          is_involution;
	logic                          last;

	modport source (output valid, output read_value, output pair_first,
		output pair_second, output is_involution, output last, input ready);
	modport sink   (input valid, input read_value, input pair_first,
		input pair_second, input is_involution, input last, output ready);
endinterface

// ===== design/permutation_table_engine_unit.sv =====
// ----------------------------------------------------------------------------
// Permutation table engine
// Forward and inverse letter tables with load, swap, read and involution test.
// ----------------------------------------------------------------------------
// Usage: the cfg channel writes size_in_use (always ready, write only while
// the engine is idle). The item channel takes one command word at a time;
// ready is high only while the sequencer is idle. Loads and swaps return no
// word, reads return one word, the involution test returns one failing word
// or up to sixteen pair words, the final one flagged by last.
// A dropped load or an unknown code leaves the sequencer idle. Every position
// or value reduction runs through a bit-serial remainder unit, and each table
// has a single read and a single write port, so the test walks the table twice.
// Reset clears the sequencer, the output register and sets size_in_use to 26;
// the table memories hold no reset value and must be loaded before use.
// A stalled receiver holds the result register; the next command word is
// still accepted, and the sequencer waits only when it has a word to emit.
// ----------------------------------------------------------------------------
`include "permutation_table_engine_unit_defines.svh"

module permutation_table_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	pte_cfg_if.sink     cfg,
	pte_item_if.sink    item,
	pte_result_if.source result
);

	localparam int LW = pte_pkg::LETTER_W;

	// Configuration and effective alphabet size.
	logic [pte_pkg::SIZE_W-1:0] size_q;
	logic [pte_pkg::SIZE_W-1:0] n_eff;

	// Sequencer state.
	pte_pkg::state_t state_q, state_d;
	pte_pkg::state_t mod_ret_q, mod_ret;

	// Latched command word.
	logic [pte_pkg::CMD_W-1:0] cmd_q;
	logic [pte_pkg::IN_W-1:0]  ia_q;
	logic [pte_pkg::IN_W-1:0]  ib_q;

	// Bit-serial remainder unit.
	logic [pte_pkg::IN_W-1:0]     mod_x_q;
	logic [LW-1:0]                mod_rem_q;
	logic [LW-1:0]                mod_rem_d;
	logic [LW:0]                  mod_trial;
	logic [pte_pkg::MODCNT_W-1:0] mod_cnt_q;
	logic                         mod_start;
	logic [pte_pkg::IN_W-1:0]     mod_src;

	// Table memories with registered read data.
	logic [LW-1:0] fwd_mem [pte_pkg::MAX_LETTERS];
	logic [LW-1:0] inv_mem [pte_pkg::MAX_LETTERS];
	logic [LW-1:0] fwd_rd_q, inv_rd_q;
	logic [LW-1:0] fwd_raddr, inv_raddr;
	logic          fwd_we, inv_we;
	logic [LW-1:0] fwd_waddr, fwd_wdata, inv_waddr, inv_wdata;

	// Swap scratch registers.
	logic [LW-1:0] p1_q, p2_q, v1_q, v2_q, t1_q;

	// Table scan for the involution test.
	logic [LW-1:0]                 c_q;
	logic                          c_clr, c_inc, c_last;
	logic [pte_pkg::PAIRCNT_W-1:0] pair_cnt_q;
	logic                          pend_v_q;
	logic [LW-1:0]                 pend_first_q, pend_second_q;
	logic                          pend_load, pend_clr;
	logic                          hit;
	logic                          scanning;

	// Output register.
	logic          out_valid_q;
	logic          out_free;
	logic          emit;
	logic [LW-1:0] emit_rv, emit_pf, emit_ps;
	logic          emit_inv, emit_last;
	logic [LW-1:0] rv_q, pf_q, ps_q;
	logic          inv_flag_q, last_q;

	logic accept;

	assign cfg.ready  = 1'b1;
	assign item.ready = (state_q == pte_pkg::ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;

	// A size of zero behaves as one letter, anything above the table depth as
	// the full table.
	always_comb begin
		if (size_q == '0) begin
			n_eff = pte_pkg::SIZE_W'(1);
		end else if (size_q > pte_pkg::SIZE_W'(pte_pkg::MAX_LETTERS)) begin
			n_eff = pte_pkg::SIZE_W'(pte_pkg::MAX_LETTERS);
		end else begin
			n_eff = size_q;
		end
	end

	// One restoring remainder step: shift in the next dividend bit and
	// subtract the size if it fits. The partial remainder stays below n.
	assign mod_trial = {mod_rem_q, mod_x_q[pte_pkg::IN_W-1]};
	assign mod_rem_d = (mod_trial >= (LW+1)'(n_eff)) ?
		LW'(mod_trial - (LW+1)'(n_eff)) : LW'(mod_trial);

	assign c_last = (pte_pkg::SIZE_W'(c_q) == n_eff - pte_pkg::SIZE_W'(1));
	assign hit    = (c_q < fwd_rd_q);

	assign scanning = (state_q == pte_pkg::ST_T1_RD) || (state_q == pte_pkg::ST_T1_CK) ||
		(state_q == pte_pkg::ST_T2_RD) || (state_q == pte_pkg::ST_T2_CK);

	// Next state, memory ports and result word.
	always_comb begin
		state_d   = state_q;
		mod_start = 1'b0;
		mod_src   = '0;
		mod_ret   = pte_pkg::ST_IDLE;
		fwd_raddr = '0;
		inv_raddr = '0;
		fwd_we    = 1'b0;
		fwd_waddr = '0;
		fwd_wdata = '0;
		inv_we    = 1'b0;
		inv_waddr = '0;
		inv_wdata = '0;
		c_clr     = 1'b0;
		c_inc     = 1'b0;
		pend_load = 1'b0;
		pend_clr  = 1'b0;
		emit      = 1'b0;
		emit_rv   = '0;
		emit_pf   = '0;
		emit_ps   = '0;
		emit_inv  = 1'b0;
		emit_last = 1'b0;

		unique case (state_q)
			pte_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (item.cmd) inside
						pte_pkg::CMD_LOAD: begin
							// Positions at or past the size are dropped.
							if (item.index_a < pte_pkg::IN_W'(n_eff)) begin
								mod_start = 1'b1;
								mod_src   = item.entry_value;
								mod_ret   = pte_pkg::ST_LD_WR;
								state_d   = pte_pkg::ST_MOD;
							end
						end
						pte_pkg::CMD_SWAP: begin
							mod_start = 1'b1;
							mod_src   = item.index_a;
							mod_ret   = pte_pkg::ST_SW_P1;
							state_d   = pte_pkg::ST_MOD;
						end
						pte_pkg::CMD_RD_FWD, pte_pkg::CMD_RD_INV: begin
							mod_start = 1'b1;
							mod_src   = item.index_a;
							mod_ret   = pte_pkg::ST_RD_A;
							state_d   = pte_pkg::ST_MOD;
						end
						pte_pkg::CMD_TEST: begin
							c_clr   = 1'b1;
							state_d = pte_pkg::ST_T1_RD;
						end
						default: begin
							state_d = pte_pkg::ST_IDLE;
						end
					endcase
				end
			end
			pte_pkg::ST_MOD: begin
				if (mod_cnt_q == pte_pkg::MODCNT_W'(pte_pkg::IN_W - 1)) begin
					state_d = mod_ret_q;
				end
			end
			pte_pkg::ST_LD_WR: begin
				fwd_we    = 1'b1;
				fwd_waddr = ia_q[LW-1:0];
				fwd_wdata = mod_rem_q;
				inv_we    = 1'b1;
				inv_waddr = mod_rem_q;
				inv_wdata = ia_q[LW-1:0];
				state_d   = pte_pkg::ST_IDLE;
			end
			pte_pkg::ST_SW_P1: begin
				mod_start = 1'b1;
				mod_src   = ib_q;
				mod_ret   = pte_pkg::ST_SW_P2;
				state_d   = pte_pkg::ST_MOD;
			end
			pte_pkg::ST_SW_P2: begin
				fwd_raddr = p1_q;
				state_d   = pte_pkg::ST_SW_R1;
			end
			pte_pkg::ST_SW_R1: begin
				mod_start = 1'b1;
				mod_src   = pte_pkg::IN_W'(fwd_rd_q);
				mod_ret   = pte_pkg::ST_SW_V1;
				state_d   = pte_pkg::ST_MOD;
			end
			pte_pkg::ST_SW_V1: begin
				fwd_raddr = p2_q;
				state_d   = pte_pkg::ST_SW_R2;
			end
			pte_pkg::ST_SW_R2: begin
				mod_start = 1'b1;
				mod_src   = pte_pkg::IN_W'(fwd_rd_q);
				mod_ret   = pte_pkg::ST_SW_V2;
				state_d   = pte_pkg::ST_MOD;
			end
			pte_pkg::ST_SW_V2: begin
				fwd_we    = 1'b1;
				fwd_waddr = p1_q;
				fwd_wdata = mod_rem_q;
				inv_raddr = v1_q;
				state_d   = pte_pkg::ST_SW_W2;
			end
			pte_pkg::ST_SW_W2: begin
				fwd_we    = 1'b1;
				fwd_waddr = p2_q;
				fwd_wdata = v1_q;
				inv_raddr = v2_q;
				state_d   = pte_pkg::ST_SW_W3;
			end
			pte_pkg::ST_SW_W3: begin
				inv_we    = 1'b1;
				inv_waddr = v1_q;
				inv_wdata = inv_rd_q;
				state_d   = pte_pkg::ST_SW_W4;
			end
			pte_pkg::ST_SW_W4: begin
				inv_we    = 1'b1;
				inv_waddr = v2_q;
				inv_wdata = t1_q;
				state_d   = pte_pkg::ST_IDLE;
			end
			pte_pkg::ST_RD_A: begin
				fwd_raddr = mod_rem_q;
				inv_raddr = mod_rem_q;
				state_d   = pte_pkg::ST_RD_E;
			end
			pte_pkg::ST_RD_E: begin
				// Keep the address so the read data holds while we wait.
				fwd_raddr = mod_rem_q;
				inv_raddr = mod_rem_q;
				if (out_free) begin
					emit      = 1'b1;
					emit_rv   = (cmd_q == pte_pkg::CMD_RD_INV) ? inv_rd_q : fwd_rd_q;
					emit_last = 1'b1;
					state_d   = pte_pkg::ST_IDLE;
				end
			end
			pte_pkg::ST_T1_RD: begin
				fwd_raddr = c_q;
				inv_raddr = c_q;
				state_d   = pte_pkg::ST_T1_CK;
			end
			pte_pkg::ST_T1_CK: begin
				fwd_raddr = c_q;
				inv_raddr = c_q;
				if ((fwd_rd_q == c_q) || (fwd_rd_q != inv_rd_q)) begin
					// Fixed point or asymmetric entry: report one failing word.
					pend_clr = 1'b1;
					state_d  = pte_pkg::ST_T2_END;
				end else if (c_last) begin
					pend_clr = 1'b1;
					c_clr    = 1'b1;
					state_d  = pte_pkg::ST_T2_RD;
				end else begin
					c_inc   = 1'b1;
					state_d = pte_pkg::ST_T1_RD;
				end
			end
			pte_pkg::ST_T2_RD: begin
				fwd_raddr = c_q;
				state_d   = pte_pkg::ST_T2_CK;
			end
			pte_pkg::ST_T2_CK: begin
				fwd_raddr = c_q;
				// A found pair is held back one step so the final one can carry
				// the last flag; it goes out when the next pair turns up.
				if (!(hit && pend_v_q && !out_free)) begin
					if (hit) begin
						pend_load = 1'b1;
						emit      = pend_v_q;
						emit_pf   = pend_first_q;
						emit_ps   = pend_second_q;
						emit_inv  = 1'b1;
					end
					if ((hit && (pair_cnt_q == pte_pkg::PAIRCNT_W'(pte_pkg::MAX_RESULTS - 1)))
							|| c_last) begin
						state_d = pte_pkg::ST_T2_END;
					end else begin
						c_inc   = 1'b1;
						state_d = pte_pkg::ST_T2_RD;
					end
				end
			end
			pte_pkg::ST_T2_END: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_pf   = pend_v_q ? pend_first_q : '0;
					emit_ps   = pend_v_q ? pend_second_q : '0;
					emit_inv  = pend_v_q;
					emit_last = 1'b1;
					state_d   = pte_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pte_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pte_pkg::ST_IDLE;
			mod_ret_q   <= pte_pkg::ST_IDLE;
			mod_cnt_q   <= '0;
			size_q      <= pte_pkg::SIZE_RESET;
			c_q         <= '0;
			pair_cnt_q  <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				size_q <= cfg.size_in_use;
			end
			if (mod_start) begin
				mod_ret_q <= mod_ret;
				mod_cnt_q <= '0;
			end else if (state_q == pte_pkg::ST_MOD) begin
				mod_cnt_q <= mod_cnt_q + pte_pkg::MODCNT_W'(1);
			end
			if (c_clr) begin
				c_q <= '0;
			end else if (c_inc) begin
				c_q <= c_q + LW'(1);
			end
			if (pend_clr) begin
				pend_v_q   <= 1'b0;
				pair_cnt_q <= '0;
			end else if (pend_load) begin
				pend_v_q   <= 1'b1;
				pair_cnt_q <= pair_cnt_q + pte_pkg::PAIRCNT_W'(1);
			end
			out_valid_q <= emit || (out_valid_q && !result.ready);
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= item.cmd;
			ia_q  <= item.index_a;
			ib_q  <= item.index_b;
		end
		if (mod_start) begin
			mod_x_q   <= mod_src;
			mod_rem_q <= '0;
		end else if (state_q == pte_pkg::ST_MOD) begin
			mod_x_q   <= mod_x_q << 1;
			mod_rem_q <= mod_rem_d;
		end
		if (state_q == pte_pkg::ST_SW_P1) begin
			p1_q <= mod_rem_q;
		end
		if (state_q == pte_pkg::ST_SW_P2) begin
			p2_q <= mod_rem_q;
		end
		if (state_q == pte_pkg::ST_SW_V1) begin
			v1_q <= mod_rem_q;
		end
		if (state_q == pte_pkg::ST_SW_V2) begin
			v2_q <= mod_rem_q;
		end
		if (state_q == pte_pkg::ST_SW_W2) begin
			t1_q <= inv_rd_q;
		end
		if (pend_load) begin
			pend_first_q  <= c_q;
			pend_second_q <= fwd_rd_q;
		end
		if (emit) begin
			rv_q       <= emit_rv;
			pf_q       <= emit_pf;
			ps_q       <= emit_ps;
			inv_flag_q <= emit_inv;
			last_q     <= emit_last;
		end
	end

	// Table memories: one write and one registered read port each.
	always_ff @(posedge clk) begin
		if (fwd_we) begin
			fwd_mem[fwd_waddr] <= fwd_wdata;
		end
		fwd_rd_q <= fwd_mem[fwd_raddr];
	end

	always_ff @(posedge clk) begin
		if (inv_we) begin
			inv_mem[inv_waddr] <= inv_wdata;
		end
		inv_rd_q <= inv_mem[inv_raddr];
	end

	assign result.valid         = out_valid_q;
	assign result.read_value    = rv_q;
	assign result.pair_first    = pf_q;
	assign result.pair_second   = ps_q;
	assign result.is_involution = inv_flag_q;
	assign result.last          = last_q;

	// The scan index never walks past the letters in use.
	`PTE_ASSERT_NOW(a_scan_in_range, scanning, pte_pkg::SIZE_W'(c_q) < n_eff, "scan index beyond alphabet size")

	// A held pair is always ordered as the listing requires.
	`PTE_ASSERT_NOW(a_pend_ordered, pend_v_q, pend_first_q < pend_second_q, "held pair is not ascending")

	// Closing the test with room in the output register puts a word out.
	`PTE_ASSERT_NEXT(a_end_emits, (state_q == pte_pkg::ST_T2_END) && out_free, out_valid_q && last_q, "test end produced no final word")

endmodule
